// ===== hdl/cse_pkg.sv =====
// Shared operation and status codes of the counting semaphore engine.
package cse_pkg;

  typedef enum logic [2:0] {
    MODE_OPEN  = 3'd0,
    MODE_CLOSE = 3'd1,
    MODE_POST  = 3'd2,
    MODE_WAIT  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_BAD     = 3'd2,
    ST_FULL    = 3'd3,
    ST_QFULL   = 3'd4
  } status_t;

  localparam int COUNT_W   = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

endpackage

// ===== hdl/cse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/counting_semaphore_engine.sv =====
// Counting semaphore engine: a table of semaphores, each with a FIFO of waiting processes.
//
// Usage:
//   in_*  : one request item per handshake; tdata holds mode, sem_id, name_key, proc_id.
//   out_* : exactly one result item per request; tdata holds status, result_id,
//           count_out, woken_valid, woken_proc, had_waiters.
// Requests are processed one at a time by a small sequencer around one counter
// adder, one key comparator and three RAMs (keys, per-slot count/queue pointers,
// wait queue entries). in_tready is high only while the sequencer is idle.
// Steps from accept to the result:
//   open           : keys compared slot by slot in S_SCAN; a match goes on through
//                    S_MRD and S_MOP, no match allocates a slot or reports full;
//                    the key RAM is read one slot per cycle.
//   close/wait/read/post: S_MRD, S_MOP; a post that wakes a waiter adds S_WRES.
//   bad slot, unused mode: straight to S_FIN, where the result register is loaded.
// in_tready returns as the result is loaded, in the same cycle that out_tvalid rises.
// The result sits in an output register, so the next request can be taken while
// a result waits; a result that is still stalled holds the sequencer in its
// final step until out_tready frees the register.
// Reset (rst_n low, synchronous) clears slot valid bits, the allocation pointer
// and the handshake state; RAM contents need no clearing.
module counting_semaphore_engine #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 8,
  parameter int PROC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] mode, [6:3] sem_id, [70:7] name_key, [78:71] proc_id, [79] zero
  input  logic [cse_pkg::IN_DATA_W-1:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [6:3] result_id, [22:7] count_out, [23] woken_valid,
  // [31:24] woken_proc, [32] had_waiters, [39:33] zero
  output logic [cse_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int SW  = $clog2(NUM_SEMS);
  localparam int NW  = $clog2(NUM_SEMS + 1);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = (PROC_BITS < 8) ? PROC_BITS : 8;
  localparam int AW  = $clog2(NUM_SEMS * QUEUE_DEPTH);
  localparam int CW  = cse_pkg::COUNT_W;
  localparam int MW  = CW + 2 * QW + FW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MRD  = 6'b000100,
    S_MOP  = 6'b001000,
    S_WRES = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t          state_r;
  logic [NUM_SEMS-1:0] valid_r;
  logic [NW-1:0]   next_slot_r;
  logic [NW-1:0]   scan_r;
  logic            pend_r;
  logic [SW-1:0]   pidx_r;
  logic [2:0]      op_r;
  logic [SW-1:0]   sid_r;
  logic [63:0]     key_r;
  logic [PW-1:0]   pid_r;

  logic [2:0]      res_status_r;
  logic [3:0]      res_rid_r;
  logic [CW-1:0]   res_cnt_r;
  logic            res_wv_r;
  logic [7:0]      res_wp_r;
  logic            res_hw_r;
  logic            out_valid_r;
  logic [cse_pkg::OUT_DATA_W-1:0] out_data_r;

  // request fields
  logic [2:0]  in_mode;
  logic [3:0]  in_sem_id;
  logic [63:0] in_name_key;
  logic [7:0]  in_proc_id;

  assign in_mode     = in_tdata[2:0];
  assign in_sem_id   = in_tdata[6:3];
  assign in_name_key = in_tdata[70:7];
  assign in_proc_id  = in_tdata[78:71];

  // RAM ports
  logic          key_we;
  logic [63:0]   key_q;
  logic          meta_we;
  logic [SW-1:0] meta_waddr;
  logic [MW-1:0] meta_wdata;
  logic [MW-1:0] meta_q;
  logic          wq_we;
  logic [AW-1:0] wq_waddr;
  logic [AW-1:0] wq_raddr;
  logic [PW-1:0] wq_q;

  logic [CW-1:0] m_count;
  logic [QW-1:0] m_head;
  logic [QW-1:0] m_tail;
  logic [FW-1:0] m_fill;

  assign {m_fill, m_tail, m_head, m_count} = meta_q;

  function automatic logic [QW-1:0] bump(input logic [QW-1:0] p);
    logic [QW:0] s;
    s = {1'b0, p} + (QW+1)'(1);
    return (s >= (QW+1)'(QUEUE_DEPTH)) ? '0 : s[QW-1:0];
  endfunction

  function automatic logic [AW-1:0] wq_addr(input logic [SW-1:0] slot,
                                            input logic [QW-1:0] ptr);
    return AW'(slot) * AW'(QUEUE_DEPTH) + AW'(ptr);
  endfunction

  logic          hit;
  logic          scan_more;
  logic          sid_ok;
  logic          wake;
  logic          q_full;
  logic [CW-1:0] cnt_sum;

  assign hit       = pend_r && valid_r[pidx_r] && (key_q == key_r);
  assign scan_more = scan_r < next_slot_r;
  assign sid_ok    = (32'(in_sem_id) < NUM_SEMS) && valid_r[SW'(in_sem_id)];
  assign wake      = (m_count == '0) && (m_fill != '0);
  assign q_full    = m_fill >= FW'(QUEUE_DEPTH);
  // shared counter adder: wait takes one, post adds one
  assign cnt_sum   = m_count + ((op_r == cse_pkg::MODE_WAIT) ? CNT_MAX : CW'(1));

  assign wq_waddr  = wq_addr(sid_r, m_tail);
  assign wq_raddr  = wq_addr(sid_r, m_head);

  always_comb begin
    key_we     = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = sid_r;
    meta_wdata = meta_q;
    wq_we      = 1'b0;
    unique case (state_r)
      S_SCAN: begin
        if (!hit && !scan_more && !pend_r && (next_slot_r != NW'(NUM_SEMS))) begin
          key_we     = 1'b1;
          meta_we    = 1'b1;
          meta_waddr = next_slot_r[SW-1:0];
          meta_wdata = '0;
        end
      end
      S_MOP: begin
        priority case (op_r)
          cse_pkg::MODE_CLOSE: begin
            meta_we    = 1'b1;
            meta_wdata = {FW'(0), QW'(0), QW'(0), m_count};
          end
          cse_pkg::MODE_POST: begin
            if (wake) begin
              meta_we    = 1'b1;
              meta_wdata = {m_fill - FW'(1), m_tail, bump(m_head), CW'(0)};
            end else if (m_count != CNT_MAX) begin
              meta_we    = 1'b1;
              meta_wdata = {m_fill, m_tail, m_head, cnt_sum};
            end
          end
          cse_pkg::MODE_WAIT: begin
            if (m_count != '0) begin
              meta_we    = 1'b1;
              meta_wdata = {m_fill, m_tail, m_head, cnt_sum};
            end else if (!q_full) begin
              wq_we      = 1'b1;
              meta_we    = 1'b1;
              meta_wdata = {m_fill + FW'(1), bump(m_tail), m_head, m_count};
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  cse_ram #(.WIDTH(64), .DEPTH(NUM_SEMS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (next_slot_r[SW-1:0]),
    .wdata (key_r),
    .raddr (scan_r[SW-1:0]),
    .rdata (key_q)
  );

  cse_ram #(.WIDTH(MW), .DEPTH(NUM_SEMS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (sid_r),
    .rdata (meta_q)
  );

  cse_ram #(.WIDTH(PW), .DEPTH(NUM_SEMS * QUEUE_DEPTH)) u_wq_ram (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (pid_r),
    .raddr (wq_raddr),
    .rdata (wq_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_slot_r <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r         <= in_mode;
            sid_r        <= SW'(in_sem_id);
            key_r        <= in_name_key;
            pid_r        <= PW'(in_proc_id);
            res_status_r <= cse_pkg::ST_OK;
            res_rid_r    <= in_sem_id;
            res_cnt_r    <= '0;
            res_wv_r     <= 1'b0;
            res_wp_r     <= '0;
            res_hw_r     <= 1'b0;
            if (in_mode == cse_pkg::MODE_OPEN) begin
              scan_r  <= '0;
              pend_r  <= 1'b0;
              state_r <= S_SCAN;
            end else if (in_mode <= cse_pkg::MODE_READ) begin
              if (sid_ok) begin
                state_r <= S_MRD;
              end else begin
                res_status_r <= cse_pkg::ST_BAD;
                state_r      <= S_FIN;
              end
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          // key read issued in the cycle before its compare
          if (hit) begin
            sid_r     <= pidx_r;
            res_rid_r <= 4'(pidx_r);
            pend_r    <= 1'b0;
            state_r   <= S_MRD;
          end else if (scan_more) begin
            pend_r <= 1'b1;
            pidx_r <= scan_r[SW-1:0];
            scan_r <= scan_r + NW'(1);
          end else if (pend_r) begin
            pend_r <= 1'b0;
          end else if (next_slot_r == NW'(NUM_SEMS)) begin
            res_status_r <= cse_pkg::ST_FULL;
            res_rid_r    <= '0;
            state_r      <= S_FIN;
          end else begin
            valid_r[next_slot_r[SW-1:0]] <= 1'b1;
            res_rid_r   <= 4'(next_slot_r);
            next_slot_r <= next_slot_r + NW'(1);
            state_r     <= S_FIN;
          end
        end
        S_MRD: begin
          state_r <= S_MOP;
        end
        S_MOP: begin
          state_r <= ((op_r == cse_pkg::MODE_POST) && wake) ? S_WRES : S_FIN;
          priority case (op_r)
            cse_pkg::MODE_CLOSE: begin
              res_hw_r       <= (m_fill != '0);
              valid_r[sid_r] <= 1'b0;
            end
            cse_pkg::MODE_POST: begin
              if (wake) begin
                res_wv_r <= 1'b1;
              end else if (m_count != CNT_MAX) begin
                res_cnt_r <= cnt_sum;
              end else begin
                res_cnt_r <= m_count;
              end
            end
            cse_pkg::MODE_WAIT: begin
              if (m_count != '0) begin
                res_cnt_r <= cnt_sum;
              end else if (q_full) begin
                res_status_r <= cse_pkg::ST_QFULL;
              end else begin
                res_status_r <= cse_pkg::ST_BLOCKED;
              end
            end
            default: begin
              res_cnt_r <= m_count;
            end
          endcase
        end
        S_WRES: begin
          res_wp_r <= 8'(wq_q);
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, res_hw_r, res_wp_r, res_wv_r, res_cnt_r,
                            res_rid_r, res_status_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/cse_checker.sv =====
// Port-level checks for the counting semaphore engine, bound to the top level.
module cse_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a blocked wait reports no count and wakes nobody
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == cse_pkg::ST_BLOCKED)
      |-> (out_tdata[22:7] == '0) && !out_tdata[23])
    else $error("blocked wait with count or wake");

  // hand-over reports OK and leaves the count at zero
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[23]
      |-> (out_tdata[2:0] == cse_pkg::ST_OK) && (out_tdata[22:7] == '0))
    else $error("wake with nonzero count or error status");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("handshake not idle after reset");

endmodule

bind counting_semaphore_engine cse_checker u_cse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
